// ===== hw/rtl/point_set_mean_covariance_macros.svh =====
// Assertion macros used by the checker of the point set block.
// The file that uses them provides clk_i and rst_ni.
`ifndef POINT_SET_MEAN_COVARIANCE_MACROS_SVH
`define POINT_SET_MEAN_COVARIANCE_MACROS_SVH

// Same-cycle implication.
`define PSMC_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// Next-cycle implication.
`define PSMC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

// ===== hw/rtl/psmc_pkg.sv =====
`timescale 1ns / 1ps
package psmc_pkg;

  localparam int COORD_BITS = 20;
  localparam int MAX_POINTS = 1024;
  localparam int CNT_W      = $clog2(MAX_POINTS + 1);
  localparam int SUM_W      = COORD_BITS + $clog2(MAX_POINTS);
  localparam int PRD_W      = 2 * COORD_BITS;
  localparam int PSUM_W     = PRD_W + $clog2(MAX_POINTS);
  localparam int LO_W       = PSUM_W / 2;
  localparam int HI_W       = PSUM_W - LO_W;
  localparam int NUM_W      = CNT_W + PSUM_W;
  localparam int DIV_W      = 2 * CNT_W;
  localparam int DCNT_W     = $clog2(NUM_W);
  localparam int MEAN_W     = COORD_BITS;
  localparam int COV_W      = 2 * COORD_BITS;
  localparam int NUM_MEAN   = 3;
  localparam int NUM_COV    = 6;
  localparam int NUM_RES    = NUM_MEAN + NUM_COV;
  localparam int IDX_W      = $clog2(NUM_RES);
  localparam int QDEPTH     = 2;
  localparam int QPTR_W     = $clog2(QDEPTH);
  localparam int QCNT_W     = $clog2(QDEPTH + 1);

  typedef struct packed {
    logic signed [COORD_BITS-1:0] coord_x;
    logic signed [COORD_BITS-1:0] coord_y;
    logic signed [COORD_BITS-1:0] coord_z;
    logic                         last_point;
  } point_t;

  typedef struct packed {
    logic signed [MEAN_W-1:0] mean_x;
    logic signed [MEAN_W-1:0] mean_y;
    logic signed [MEAN_W-1:0] mean_z;
    logic signed [COV_W-1:0]  cov_xx;
    logic signed [COV_W-1:0]  cov_xy;
    logic signed [COV_W-1:0]  cov_xz;
    logic signed [COV_W-1:0]  cov_yy;
    logic signed [COV_W-1:0]  cov_yz;
    logic signed [COV_W-1:0]  cov_zz;
    logic [CNT_W-1:0]         num_points;
    logic                     overflow;
  } result_t;

  // Totals of one closed set, handed from front to back.
  typedef struct packed {
    logic [CNT_W-1:0]                       count;
    logic                                   dropped;
    logic [NUM_MEAN-1:0][SUM_W-1:0]         sum;
    logic [NUM_COV-1:0][PSUM_W-1:0]         psum;
  } set_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_MUL,
    BK_NUM,
    BK_GO,
    BK_DIV,
    BK_OUT
  } back_state_e;

  // First and second axis of each second-moment term: xx xy xz yy yz zz.
  function automatic logic [1:0] axis_a(input logic [2:0] k);
    logic [1:0] r;
    case (k)
      3'd0, 3'd1, 3'd2: r = 2'd0;
      3'd3, 3'd4:       r = 2'd1;
      3'd5:             r = 2'd2;
      default:          r = 2'd0;
    endcase
    return r;
  endfunction

  function automatic logic [1:0] axis_b(input logic [2:0] k);
    logic [1:0] r;
    case (k)
      3'd0:       r = 2'd0;
      3'd1, 3'd3: r = 2'd1;
      3'd2, 3'd4: r = 2'd2;
      3'd5:       r = 2'd2;
      default:    r = 2'd0;
    endcase
    return r;
  endfunction

endpackage

// ===== hw/rtl/point_set_mean_covariance.sv =====
`timescale 1ns / 1ps
// Centroid and 3x3 covariance of sets of 3D points.
// Input channel (in_valid_i / in_stall_o / in_data_i): one point per transfer,
// coordinates signed millimetres, last_point closes the set. Output channel
// (out_valid_o / out_stall_i / out_data_o): one result per closed set with
// the truncated mean, six covariance terms, point count and overflow flag.
// Throughput: one point per cycle into the accumulator while in_stall_o is low;
// a point passes the input register and the multiply stage before the add stage.
// A result is computed after the closing point by the single shared divider:
// nine divisions of 61 quotient bits, one bit a cycle, each sequenced through
// the multiply, numerator and start states of the back end.
// A two-entry queue between accumulator and divider back end lets the next
// set stream in while the previous one is being divided; input stalls only
// when a closing point finds that queue full.
// When the receiver stalls, the result is held on out_data_o unchanged.
// Reset clears the running sums, the queue and the back-end sequencer; no
// clearing pass is needed.
module point_set_mean_covariance import psmc_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_stall_o,
  input  point_t  in_data_i,
  output logic    out_valid_o,
  input  logic    out_stall_i,
  output result_t out_data_o
);

  logic                    push;
  logic                    full;
  logic                    q_valid;
  logic                    pop;
  set_t                    set_in;
  set_t                    set_out;
  logic                    div_start;
  logic                    div_done;
  logic signed [NUM_W-1:0] div_dividend;
  logic [DIV_W-1:0]        div_divisor;
  logic signed [NUM_W-1:0] div_quot;

  // Accumulate points; emit set totals on the closing point.
  psmc_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .push_o     (push),
    .set_o      (set_in),
    .full_i     (full)
  );

  // Decouple accumulation from division.
  psmc_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (set_in),
    .full_o  (full),
    .pop_i   (pop),
    .valid_o (q_valid),
    .data_o  (set_out)
  );

  // Sequence means and covariances through the shared divider.
  psmc_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .q_valid_i      (q_valid),
    .q_set_i        (set_out),
    .pop_o          (pop),
    .div_start_o    (div_start),
    .div_dividend_o (div_dividend),
    .div_divisor_o  (div_divisor),
    .div_done_i     (div_done),
    .div_quot_i     (div_quot),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .out_data_o     (out_data_o)
  );

  psmc_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .done_o     (div_done),
    .quot_o     (div_quot)
  );

endmodule

// ===== hw/rtl/psmc_front.sv =====
`timescale 1ns / 1ps
module psmc_front import psmc_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   in_valid_i,
  output logic   in_stall_o,
  input  point_t in_data_i,
  output logic   push_o,
  output set_t   set_o,
  input  logic   full_i
);

  logic                       s1_valid_q;
  point_t                     s1_q;
  logic                       s2_valid_q;
  logic                       s2_last_q;
  logic signed [COORD_BITS-1:0] s2_c_q [NUM_MEAN];
  logic signed [PRD_W-1:0]    s2_p_q [NUM_COV];
  logic signed [COORD_BITS-1:0] c1 [NUM_MEAN];
  logic signed [PRD_W-1:0]    p1 [NUM_COV];

  logic [CNT_W-1:0]           count_q;
  logic                       dropped_q;
  logic [SUM_W-1:0]           sum_q [NUM_MEAN];
  logic [PSUM_W-1:0]          psum_q [NUM_COV];
  logic [SUM_W-1:0]           sum_n [NUM_MEAN];
  logic [PSUM_W-1:0]          psum_n [NUM_COV];
  logic                       adv;
  logic                       take;

  // Hold the pipe while a closing point waits on a full queue.
  assign adv        = !(s2_valid_q && s2_last_q && full_i);
  assign in_stall_o = !adv;
  assign take       = count_q < CNT_W'(MAX_POINTS);
  assign push_o     = adv && s2_valid_q && s2_last_q;

  assign c1[0] = s1_q.coord_x;
  assign c1[1] = s1_q.coord_y;
  assign c1[2] = s1_q.coord_z;

  always_comb begin
    for (int k = 0; k < NUM_COV; k++) begin
      p1[k] = c1[axis_a(3'(k))] * c1[axis_b(3'(k))];
    end
    for (int i = 0; i < NUM_MEAN; i++) begin
      sum_n[i] = sum_q[i] + SUM_W'(s2_c_q[i]);
    end
    for (int k = 0; k < NUM_COV; k++) begin
      psum_n[k] = psum_q[k] + PSUM_W'(s2_p_q[k]);
    end
  end

  always_comb begin
    set_o.count   = take ? count_q + CNT_W'(1) : count_q;
    set_o.dropped = dropped_q || !take;
    for (int i = 0; i < NUM_MEAN; i++) begin
      set_o.sum[i] = take ? sum_n[i] : sum_q[i];
    end
    for (int k = 0; k < NUM_COV; k++) begin
      set_o.psum[k] = take ? psum_n[k] : psum_q[k];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
    end else if (adv) begin
      s1_valid_q <= in_valid_i;
      s2_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_q      <= in_data_i;
      s2_last_q <= s1_q.last_point;
      for (int i = 0; i < NUM_MEAN; i++) s2_c_q[i] <= c1[i];
      for (int k = 0; k < NUM_COV; k++) s2_p_q[k] <= p1[k];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q   <= '0;
      dropped_q <= 1'b0;
      for (int i = 0; i < NUM_MEAN; i++) sum_q[i] <= '0;
      for (int k = 0; k < NUM_COV; k++) psum_q[k] <= '0;
    end else if (push_o) begin
      count_q   <= '0;
      dropped_q <= 1'b0;
      for (int i = 0; i < NUM_MEAN; i++) sum_q[i] <= '0;
      for (int k = 0; k < NUM_COV; k++) psum_q[k] <= '0;
    end else if (adv && s2_valid_q) begin
      if (take) begin
        count_q <= count_q + CNT_W'(1);
        for (int i = 0; i < NUM_MEAN; i++) sum_q[i] <= sum_n[i];
        for (int k = 0; k < NUM_COV; k++) psum_q[k] <= psum_n[k];
      end else begin
        dropped_q <= 1'b1;
      end
    end
  end

endmodule

// ===== hw/rtl/psmc_queue.sv =====
`timescale 1ns / 1ps
module psmc_queue import psmc_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  set_t data_i,
  output logic full_o,
  input  logic pop_i,
  output logic valid_o,
  output set_t data_o
);

  set_t              mem_q [QDEPTH];
  logic [QPTR_W-1:0] wp_q;
  logic [QPTR_W-1:0] rp_q;
  logic [QCNT_W-1:0] cnt_q;

  assign full_o  = cnt_q == QCNT_W'(QDEPTH);
  assign valid_o = cnt_q != '0;
  assign data_o  = mem_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wp_q] <= data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wp_q <= wp_q + QPTR_W'(1);
      if (pop_i) rp_q <= rp_q + QPTR_W'(1);
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + QCNT_W'(1);
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - QCNT_W'(1);
      end
    end
  end

endmodule

// ===== hw/rtl/psmc_div.sv =====
`timescale 1ns / 1ps
module psmc_div import psmc_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start_i,
  input  logic signed [NUM_W-1:0] dividend_i,
  input  logic [DIV_W-1:0]        divisor_i,
  output logic                    done_o,
  output logic signed [NUM_W-1:0] quot_o
);

  logic              busy_q;
  logic              done_q;
  logic              neg_q;
  logic [DCNT_W-1:0] cnt_q;
  logic [NUM_W-1:0]  quo_q;
  logic [DIV_W-1:0]  rem_q;
  logic [DIV_W-1:0]  div_q;
  logic [DIV_W:0]    trial;
  logic [DIV_W:0]    diff;
  logic              ge;

  // One quotient bit per cycle, restoring, on magnitudes.
  assign trial  = {rem_q, quo_q[NUM_W-1]};
  assign diff   = trial - {1'b0, div_q};
  assign ge     = trial >= {1'b0, div_q};
  assign done_o = done_q;
  assign quot_o = neg_q ? -$signed(quo_q) : $signed(quo_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= DCNT_W'(NUM_W - 1);
      end else if (busy_q) begin
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end else begin
          cnt_q <= cnt_q - DCNT_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      neg_q <= dividend_i[NUM_W-1];
      quo_q <= dividend_i[NUM_W-1] ? NUM_W'(-dividend_i) : NUM_W'(dividend_i);
      rem_q <= '0;
      div_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= ge ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
      quo_q <= {quo_q[NUM_W-2:0], ge};
    end
  end

endmodule

// ===== hw/rtl/psmc_back.sv =====
`timescale 1ns / 1ps
module psmc_back import psmc_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    q_valid_i,
  input  set_t                    q_set_i,
  output logic                    pop_o,
  output logic                    div_start_o,
  output logic signed [NUM_W-1:0] div_dividend_o,
  output logic [DIV_W-1:0]        div_divisor_o,
  input  logic                    div_done_i,
  input  logic signed [NUM_W-1:0] div_quot_i,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output result_t                 out_data_o
);

  back_state_e state_q, state_d;
  logic [IDX_W-1:0]                   idx_q;
  set_t                               snap_q;
  result_t                            res_q;
  logic [DIV_W-1:0]                   nn_q;
  logic [CNT_W+LO_W-1:0]              plo_q;
  logic signed [CNT_W+HI_W:0]         phi_q;
  logic signed [2*SUM_W-1:0]          pab_q;
  logic signed [NUM_W-1:0]            num_q;
  logic [CNT_W-1:0]                   n;
  logic                               is_mean;
  logic [2:0]                         kk;
  logic [PSUM_W-1:0]                  sab;
  logic signed [SUM_W-1:0]            sa;
  logic signed [SUM_W-1:0]            sb;

  assign n       = (snap_q.count == '0) ? CNT_W'(1) : snap_q.count;
  assign is_mean = idx_q < IDX_W'(NUM_MEAN);
  assign kk      = is_mean ? 3'd0 : 3'(idx_q - IDX_W'(NUM_MEAN));
  assign sab     = snap_q.psum[kk];
  assign sa      = snap_q.sum[axis_a(kk)];
  assign sb      = snap_q.sum[axis_b(kk)];

  assign div_dividend_o = num_q;
  assign div_divisor_o  = is_mean ? DIV_W'(n) : nn_q;
  assign out_valid_o    = state_q == BK_OUT;
  assign out_data_o     = res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= BK_IDLE;
    else         state_q <= state_d;
  end

  always_comb begin
    state_d     = state_q;
    pop_o       = 1'b0;
    div_start_o = 1'b0;
    unique case (state_q)
      BK_IDLE: begin
        if (q_valid_i) begin
          pop_o   = 1'b1;
          state_d = BK_MUL;
        end
      end
      BK_MUL:  state_d = BK_NUM;
      BK_NUM:  state_d = BK_GO;
      BK_GO: begin
        div_start_o = 1'b1;
        state_d     = BK_DIV;
      end
      BK_DIV: begin
        if (div_done_i) begin
          state_d = (idx_q == IDX_W'(NUM_RES - 1)) ? BK_OUT : BK_MUL;
        end
      end
      BK_OUT: begin
        if (!out_stall_i) state_d = BK_IDLE;
      end
      default: state_d = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      BK_IDLE: begin
        snap_q           <= q_set_i;
        idx_q            <= '0;
        res_q.num_points <= q_set_i.count;
        res_q.overflow   <= q_set_i.dropped;
      end
      BK_MUL: begin
        nn_q  <= n * n;
        plo_q <= n * sab[LO_W-1:0];
        phi_q <= $signed({1'b0, n}) * $signed(sab[PSUM_W-1:LO_W]);
        pab_q <= sa * sb;
      end
      BK_NUM: begin
        if (is_mean) begin
          num_q <= NUM_W'($signed(snap_q.sum[idx_q[1:0]]));
        end else begin
          num_q <= (NUM_W'(phi_q) <<< LO_W) + $signed(NUM_W'(plo_q)) - NUM_W'(pab_q);
        end
      end
      BK_DIV: begin
        if (div_done_i) begin
          idx_q <= idx_q + IDX_W'(1);
          case (idx_q)
            4'd0:    res_q.mean_x <= div_quot_i[MEAN_W-1:0];
            4'd1:    res_q.mean_y <= div_quot_i[MEAN_W-1:0];
            4'd2:    res_q.mean_z <= div_quot_i[MEAN_W-1:0];
            4'd3:    res_q.cov_xx <= div_quot_i[COV_W-1:0];
            4'd4:    res_q.cov_xy <= div_quot_i[COV_W-1:0];
            4'd5:    res_q.cov_xz <= div_quot_i[COV_W-1:0];
            4'd6:    res_q.cov_yy <= div_quot_i[COV_W-1:0];
            4'd7:    res_q.cov_yz <= div_quot_i[COV_W-1:0];
            default: res_q.cov_zz <= div_quot_i[COV_W-1:0];
          endcase
        end
      end
      default: begin
      end
    endcase
  end

endmodule

// ===== hw/rtl/psmc_checker.sv =====
`timescale 1ns / 1ps
`include "point_set_mean_covariance_macros.svh"
module psmc_checker import psmc_pkg::*; (
  input logic    clk_i,
  input logic    rst_ni,
  input logic    out_valid_o,
  input logic    out_stall_i,
  input result_t out_data_o
);

  `PSMC_ASSERT_NEXT(a_out_valid_hold, out_valid_o && out_stall_i, out_valid_o)
  `PSMC_ASSERT_NEXT(a_out_data_hold, out_valid_o && out_stall_i, $stable(out_data_o))
  `PSMC_ASSERT_NOW(a_count_nonzero, out_valid_o, out_data_o.num_points != '0)
  `PSMC_ASSERT_NOW(a_drop_only_full, out_valid_o && out_data_o.overflow, out_data_o.num_points == CNT_W'(MAX_POINTS))

endmodule

bind point_set_mean_covariance psmc_checker u_checker (.*);
